/* design/dfe_pkg.sv */
`default_nettype none

package dfe_pkg;

  // Largest delimiter length the block honors; the window holds eight bytes.
  localparam int unsigned MAX_PATTERN_BYTES = 8;
  localparam int unsigned WIN_BYTES         = 8;
  localparam int unsigned LEN_CAP           =
      (MAX_PATTERN_BYTES < WIN_BYTES) ? MAX_PATTERN_BYTES : WIN_BYTES;

  localparam int unsigned LEN_W   = 4;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_PATTERN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_LENGTH    = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_FOUND   = 2'd1;
  localparam logic [1:0] KIND_MISSING = 2'd2;

  localparam logic [LEN_W-1:0] COUNT_MAX = 4'd15;

  typedef enum logic [2:0] {
    PH_SEEK  = 3'b001,
    PH_FIELD = 3'b010,
    PH_DONE  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       run_last;
  } out_item_t;

endpackage

`default_nettype wire

/* design/delimited_field_extractor_core.sv */
// Each result is queued as its input byte is accepted and is offered after earlier results.
// One input byte per cycle while input ready is high; each byte yields zero, one or two results.
// A four-entry result queue takes up to two results per byte and, while output ready
// is high, drains one per cycle, so input ready is low only while it holds more than two results.
// Reset (rst_ni, asynchronous, active low) clears the queue, the search state and window,
// and loads the registers with all-zero patterns of length one.
`default_nettype none

module delimited_field_extractor_core (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_we_i,
  input  wire  [dfe_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire  [dfe_pkg::CFG_W-1:0]              cfg_data_i,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  dfe_pkg::in_item_t                      in_data_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output dfe_pkg::out_item_t                     out_data_o
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Configuration registers.
  logic [63:0]                   start_pat_q;
  logic [dfe_pkg::LEN_W-1:0]     start_len_q;
  logic [63:0]                   end_pat_q;
  logic [dfe_pkg::LEN_W-1:0]     end_len_q;

  // Search state.
  dfe_pkg::phase_e               phase_q, phase_d;
  logic [63:0]                   win_q, win_d;
  logic [dfe_pkg::LEN_W-1:0]     cnt_q, cnt_d;

  // Result queue.
  dfe_pkg::out_item_t            queue_q [QDEPTH];
  logic [QPTR_W-1:0]             wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]             count_q;

  // Results produced by the byte at the input.
  dfe_pkg::out_item_t            res0, res1;
  logic [1:0]                    push_n;

  logic                          in_accept, out_accept;

  assign in_accept  = in_valid_i && in_ready_o;
  assign out_accept = out_valid_o && out_ready_i;

  // Room for the worst case of two results from the next byte.
  assign in_ready_o  = (count_q <= QCNT_W'(QDEPTH - 2));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = queue_q[rd_ptr_q];

  // Lengths above the window are treated as the window size.
  function automatic logic [dfe_pkg::LEN_W-1:0] clamp_len(input logic [dfe_pkg::LEN_W-1:0] v);
    if (v > dfe_pkg::LEN_W'(dfe_pkg::LEN_CAP)) begin
      return dfe_pkg::LEN_W'(dfe_pkg::LEN_CAP);
    end
    return v;
  endfunction

  // True when the lowest len bytes of the window equal those of the pattern.
  function automatic logic window_match(input logic [63:0] win, input logic [63:0] pat,
                                        input logic [dfe_pkg::LEN_W-1:0] len);
    logic [63:0] mask;
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = (dfe_pkg::LEN_W'(i) < len) ? 8'hFF : 8'h00;
    end
    return ((win ^ pat) & mask) == 64'd0;
  endfunction

  function automatic logic [dfe_pkg::LEN_W-1:0] sat_inc(input logic [dfe_pkg::LEN_W-1:0] v);
    return (v == dfe_pkg::COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // One pass over the incoming byte: update the search state and form up to two results.
  always_comb begin
    logic [dfe_pkg::LEN_W-1:0] slen, elen, cnt1, sel;
    logic [63:0]               win1;
    logic                      consumed;
    dfe_pkg::out_item_t        res [2];
    logic [1:0]                n;

    slen     = clamp_len(start_len_q);
    elen     = clamp_len(end_len_q);
    phase_d  = phase_q;
    win_d    = win_q;
    cnt_d    = cnt_q;
    consumed = 1'b0;
    n        = 2'd0;
    res[0]   = '0;
    res[1]   = '0;
    cnt1     = '0;
    win1     = '0;
    sel      = '0;

    // Seeking the start delimiter.
    if (phase_q == dfe_pkg::PH_SEEK) begin
      if (slen != '0) begin
        consumed = 1'b1;
        win1     = {win_q[55:0], in_data_i.data_byte};
        cnt1     = sat_inc(cnt_q);
        win_d    = win1;
        cnt_d    = cnt1;
        if ((cnt1 >= slen) && window_match(win1, start_pat_q, slen)) begin
          phase_d = dfe_pkg::PH_FIELD;
          win_d   = '0;
          cnt_d   = '0;
          if (elen == '0) begin
            res[n[0]] = '{out_byte: 8'd0, out_kind: dfe_pkg::KIND_FOUND, run_last: 1'b0};
            n         = n + 2'd1;
            phase_d   = dfe_pkg::PH_DONE;
          end
        end
      end else begin
        // An empty start pattern matches before this byte, so the byte is field data.
        phase_d = dfe_pkg::PH_FIELD;
        win_d   = '0;
        cnt_d   = '0;
      end
    end

    // Inside the field: release the byte that has aged past the end delimiter length.
    if ((phase_d == dfe_pkg::PH_FIELD) && !consumed) begin
      if (elen == '0) begin
        res[n[0]] = '{out_byte: 8'd0, out_kind: dfe_pkg::KIND_FOUND, run_last: 1'b0};
        n         = n + 2'd1;
        phase_d   = dfe_pkg::PH_DONE;
      end else begin
        if (cnt_d >= elen) begin
          sel       = elen - 1'b1;
          res[n[0]] = '{out_byte: win_d[{sel[2:0], 3'b000} +: 8],
                        out_kind: dfe_pkg::KIND_BYTE, run_last: 1'b0};
          n         = n + 2'd1;
        end
        win1  = {win_d[55:0], in_data_i.data_byte};
        cnt1  = sat_inc(cnt_d);
        win_d = win1;
        cnt_d = cnt1;
        if ((cnt1 >= elen) && window_match(win1, end_pat_q, elen)) begin
          res[n[0]] = '{out_byte: 8'd0, out_kind: dfe_pkg::KIND_FOUND, run_last: 1'b0};
          n         = n + 2'd1;
          phase_d   = dfe_pkg::PH_DONE;
        end
      end
    end

    // End of string: report a miss if no field was completed, then start fresh.
    if (in_data_i.string_end) begin
      if ((phase_d == dfe_pkg::PH_SEEK) || (phase_d == dfe_pkg::PH_FIELD)) begin
        res[n[0]] = '{out_byte: 8'd0, out_kind: dfe_pkg::KIND_MISSING, run_last: 1'b0};
        n         = n + 2'd1;
      end
      phase_d = dfe_pkg::PH_SEEK;
      win_d   = '0;
      cnt_d   = '0;
    end

    // The last result of this byte carries the run_last mark.
    case (n)
      2'd1:    res[0].run_last = 1'b1;
      2'd2:    res[1].run_last = 1'b1;
      default: ;
    endcase

    res0   = res[0];
    res1   = res[1];
    push_n = n;
  end

  // Configuration writes must arrive only while the block is idle; the user must ensure it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pat_q <= '0;
      start_len_q <= 4'd1;
      end_pat_q   <= '0;
      end_len_q   <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dfe_pkg::REG_START_PATTERN: start_pat_q <= cfg_data_i;
        dfe_pkg::REG_START_LENGTH:  start_len_q <= cfg_data_i[dfe_pkg::LEN_W-1:0];
        dfe_pkg::REG_END_PATTERN:   end_pat_q   <= cfg_data_i;
        dfe_pkg::REG_END_LENGTH:    end_len_q   <= cfg_data_i[dfe_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Search state advances on every accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dfe_pkg::PH_SEEK;
      win_q   <= '0;
      cnt_q   <= '0;
    end else if (in_accept) begin
      phase_q <= phase_d;
      win_q   <= win_d;
      cnt_q   <= cnt_d;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_accept) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
      end
      if (out_accept) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (in_accept ? QCNT_W'(push_n) : '0) - QCNT_W'(out_accept);
    end
  end

  // Queue storage; the second result of a byte goes one slot after the first.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      if (push_n != 2'd0) begin
        queue_q[wr_ptr_q] <= res0;
      end
      if (push_n == 2'd2) begin
        queue_q[wr_ptr_q + 1'b1] <= res1;
      end
    end
  end

  // The queue never holds more results than it has slots.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // The last byte of a string always leaves a clean search state behind.
  a_string_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.string_end) |=>
      (phase_q == dfe_pkg::PH_SEEK) && (cnt_q == '0) && (win_q == '0))
    else $error("search state not cleared after end of string");

  // After the field is complete, further bytes of the string produce nothing.
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (phase_q == dfe_pkg::PH_DONE) && !in_data_i.string_end) |-> (push_n == 2'd0))
    else $error("result produced after field completed");

endmodule

`default_nettype wire

/* sim/field_extract_checker.sv */
`default_nettype none

module field_extract_checker (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [dfe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [dfe_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire                            in_valid_i,
  input  wire                            in_ready_i,
  input  dfe_pkg::in_item_t              in_data_i,
  input  wire                            out_valid_i,
  input  wire                            out_ready_i,
  input  dfe_pkg::out_item_t             out_data_i,
  output int                             pending_o,
  output int                             fails_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the delimiter registers.
  logic [63:0]               open_pat  = '0;
  logic [dfe_pkg::LEN_W-1:0] open_len  = 4'd1;
  logic [63:0]               close_pat = '0;
  logic [dfe_pkg::LEN_W-1:0] close_len = 4'd1;

  // Search state of the extractor.
  logic [63:0]               recent_bytes = '0;
  dfe_pkg::phase_e           scan_phase   = dfe_pkg::PH_SEEK;
  logic [dfe_pkg::LEN_W-1:0] seen_count   = '0;

  dfe_pkg::out_item_t        expected_results[$];
  dfe_pkg::out_item_t        want;
  bit                        bad;
  int                        fail_tally = 0;

  function automatic logic [dfe_pkg::LEN_W-1:0] capped(input logic [dfe_pkg::LEN_W-1:0] len);
    return (len > dfe_pkg::LEN_CAP) ? dfe_pkg::LEN_W'(dfe_pkg::LEN_CAP) : len;
  endfunction

  // True when the newest len bytes of the window equal the low len bytes of pat.
  function automatic bit tail_matches(input logic [63:0] win, input logic [63:0] pat,
                                      input logic [dfe_pkg::LEN_W-1:0] len);
    logic [63:0] mask;
    if (len == 0) return 1'b1;
    mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
    return ((win ^ pat) & mask) == 64'd0;
  endfunction

  function automatic dfe_pkg::out_item_t make_result(input logic [7:0] value,
                                                     input logic [1:0] kind);
    dfe_pkg::out_item_t r;
    r.out_byte = value;
    r.out_kind = kind;
    r.run_last = 1'b0;
    return r;
  endfunction

  task automatic shift_in(input logic [7:0] value);
    recent_bytes = {recent_bytes[55:0], value};
    if (seen_count != dfe_pkg::COUNT_MAX) seen_count = seen_count + 1'b1;
  endtask

  task automatic extract_step(input dfe_pkg::in_item_t item);
    logic [dfe_pkg::LEN_W-1:0] slen;
    logic [dfe_pkg::LEN_W-1:0] elen;
    logic [63:0]               held;
    bit                        consumed;
    dfe_pkg::out_item_t        step_q[$];
    slen = capped(open_len);
    elen = capped(close_len);
    consumed = 1'b0;

    if (scan_phase == dfe_pkg::PH_SEEK) begin
      if (slen != 0) begin
        consumed = 1'b1;
        shift_in(item.data_byte);
        if (seen_count >= slen && tail_matches(recent_bytes, open_pat, slen)) begin
          scan_phase   = dfe_pkg::PH_FIELD;
          recent_bytes = '0;
          seen_count   = '0;
          if (elen == 0) begin
            step_q.push_back(make_result(8'h00, dfe_pkg::KIND_FOUND));
            scan_phase = dfe_pkg::PH_DONE;
          end
        end
      end else begin
        // An empty start pattern opens the field before this byte.
        scan_phase   = dfe_pkg::PH_FIELD;
        recent_bytes = '0;
        seen_count   = '0;
      end
    end

    if (scan_phase == dfe_pkg::PH_FIELD && !consumed) begin
      if (elen == 0) begin
        step_q.push_back(make_result(8'h00, dfe_pkg::KIND_FOUND));
        scan_phase = dfe_pkg::PH_DONE;
      end else begin
        // The byte leaving the hold-back window can no longer be part of the end pattern.
        if (seen_count >= elen) begin
          held = recent_bytes >> (8 * (int'(elen) - 1));
          step_q.push_back(make_result(held[7:0], dfe_pkg::KIND_BYTE));
        end
        shift_in(item.data_byte);
        if (seen_count >= elen && tail_matches(recent_bytes, close_pat, elen)) begin
          step_q.push_back(make_result(8'h00, dfe_pkg::KIND_FOUND));
          scan_phase = dfe_pkg::PH_DONE;
        end
      end
    end

    if (item.string_end) begin
      if (scan_phase != dfe_pkg::PH_DONE) begin
        step_q.push_back(make_result(8'h00, dfe_pkg::KIND_MISSING));
      end
      scan_phase   = dfe_pkg::PH_SEEK;
      recent_bytes = '0;
      seen_count   = '0;
    end

    if (step_q.size() > 0) step_q[step_q.size() - 1].run_last = 1'b1;
    foreach (step_q[i]) expected_results.push_back(step_q[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_pat     = '0;
      open_len     = 4'd1;
      close_pat    = '0;
      close_len    = 4'd1;
      recent_bytes = '0;
      scan_phase   = dfe_pkg::PH_SEEK;
      seen_count   = '0;
      fail_tally   = 0;
      expected_results.delete();
    end else begin
      // A byte taken at this edge still sees the registers as they were before it.
      if (in_valid_i && in_ready_i) extract_step(in_data_i);

      if (cfg_we_i) begin
        case (cfg_idx_i)
          dfe_pkg::REG_START_PATTERN: open_pat  = cfg_data_i;
          dfe_pkg::REG_START_LENGTH:  open_len  = cfg_data_i[dfe_pkg::LEN_W-1:0];
          dfe_pkg::REG_END_PATTERN:   close_pat = cfg_data_i;
          dfe_pkg::REG_END_LENGTH:    close_len = cfg_data_i[dfe_pkg::LEN_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %02h kind %0d last %0b",
                   $time, out_data_i.out_byte, out_data_i.out_kind, out_data_i.run_last);
          fail_tally++;
        end else begin
          want = expected_results.pop_front();
          bad  = 1'b0;
          if (out_data_i.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch, expected %02h, got %02h",
                     $time, want.out_byte, out_data_i.out_byte);
            bad = 1'b1;
          end
          if (out_data_i.out_kind !== want.out_kind) begin
            $display("%0t: out_kind mismatch, expected %0d, got %0d",
                     $time, want.out_kind, out_data_i.out_kind);
            bad = 1'b1;
          end
          if (out_data_i.run_last !== want.run_last) begin
            $display("%0t: run_last mismatch, expected %0b, got %0b",
                     $time, want.run_last, out_data_i.run_last);
            bad = 1'b1;
          end
          if (bad) fail_tally++;
        end
      end
    end
    pending_o <= expected_results.size();
    fails_o   <= fail_tally;
  end

endmodule

`default_nettype wire

/* sim/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A quiet stretch this long means the block has stopped moving transactions.
  localparam int WATCHDOG_LIMIT = 4000;
  // Length of the deliberate output hold-off that fills the result queue.
  localparam int LONG_HOLD      = 150;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 75;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we    = 1'b0;
  logic [dfe_pkg::CFG_IDX_W-1:0] cfg_idx   = dfe_pkg::REG_START_PATTERN;
  logic [dfe_pkg::CFG_W-1:0]     cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  dfe_pkg::in_item_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  dfe_pkg::out_item_t            out_data;

  int                            pending;
  int                            fail_count;
  int                            quiet_cycles = 0;

  // When calm is set, neither side inserts idle cycles.
  bit                            calm      = 1'b0;
  // Set by the stimulus for one phase; the receiver takes one long hold-off while it is set.
  bit                            long_hold = 1'b0;

  // The delimiters currently programmed, used to shape the strings sent.
  logic [63:0]                   cur_sp = '0;
  logic [dfe_pkg::LEN_W-1:0]     cur_sl = 4'd1;
  logic [63:0]                   cur_ep = '0;
  logic [dfe_pkg::LEN_W-1:0]     cur_el = 4'd1;

  // Bytes of the string being sent.
  logic [7:0]                    string_bytes[$];

  delimited_field_extractor_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // The checker sees exactly what the block sees and keeps its own expectations.
  field_extract_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .pending_o   (pending),
    .fails_o     (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The watchdog restarts on every transaction and on every register write.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: mostly ready, with short random stalls, and one long hold-off on request.
  // The long hold-off keeps the output blocked while the sender keeps offering bytes,
  // so the internal result queue fills and the block has to drop its input ready.
  initial begin : receiver
    bit held_once;
    held_once = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold && !held_once) begin
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] pick_word();
    return {$urandom, $urandom};
  endfunction

  // Lengths are mostly short so that matches are frequent; now and then any
  // 4-bit value, including zero and lengths above the cap, is used.
  function automatic logic [dfe_pkg::LEN_W-1:0] pick_len();
    logic [dfe_pkg::LEN_W-1:0] len;
    if ($urandom_range(0, 3) == 0) len = dfe_pkg::LEN_W'($urandom_range(0, 15));
    else len = dfe_pkg::LEN_W'($urandom_range(1, 3));
    return len;
  endfunction

  // A byte that is often taken from the given delimiter, so that partial and
  // overlapping matches show up inside filler and field bytes.
  function automatic logic [7:0] near_byte(input logic [63:0] pat,
                                           input logic [dfe_pkg::LEN_W-1:0] len);
    int used;
    used = int'((len > dfe_pkg::LEN_CAP) ? dfe_pkg::LEN_CAP : len);
    if (used == 0 || $urandom_range(0, 2) != 0) return 8'($urandom_range(0, 255));
    return pat[8 * $urandom_range(0, used - 1) +: 8];
  endfunction

  // Appends the first upto bytes of a delimiter, first byte from the most
  // significant used position.
  task automatic append_pattern(input logic [63:0] pat, input logic [dfe_pkg::LEN_W-1:0] len,
                                input int upto);
    int used;
    int take;
    used = int'((len > dfe_pkg::LEN_CAP) ? dfe_pkg::LEN_CAP : len);
    take = (upto < used) ? upto : used;
    for (int j = 0; j < take; j++) string_bytes.push_back(pat[8 * (used - 1 - j) +: 8]);
  endtask

  // Writes all four registers on back-to-back cycles. It is entered right after a
  // rising edge and only while nothing is in flight. Unused upper bits of the
  // length writes carry random data, which the block must ignore.
  task automatic program_regs(input logic [63:0] sp, input logic [dfe_pkg::LEN_W-1:0] sl,
                              input logic [63:0] ep, input logic [dfe_pkg::LEN_W-1:0] el);
    logic [63:0] junk;
    cur_sp = sp;
    cur_sl = sl;
    cur_ep = ep;
    cur_el = el;
    cfg_we   <= 1'b1;
    cfg_idx  <= dfe_pkg::REG_START_PATTERN;
    cfg_data <= sp;
    @(posedge clk);
    junk = pick_word();
    cfg_idx  <= dfe_pkg::REG_START_LENGTH;
    cfg_data <= {junk[63:dfe_pkg::LEN_W], sl};
    @(posedge clk);
    cfg_idx  <= dfe_pkg::REG_END_PATTERN;
    cfg_data <= ep;
    @(posedge clk);
    junk = pick_word();
    cfg_idx  <= dfe_pkg::REG_END_LENGTH;
    cfg_data <= {junk[63:dfe_pkg::LEN_W], el};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one byte and returns at the edge where the transaction takes place.
  // Valid stays high into the next byte unless a random gap is inserted.
  task automatic push_byte(input logic [7:0] value, input logic closes);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {value, closes};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sends the collected bytes; the last one carries string_end if asked.
  task automatic play_bytes(input bit ends_string);
    for (int k = 0; k < string_bytes.size(); k++)
      push_byte(string_bytes[k], ends_string && (k == string_bytes.size() - 1));
  endtask

  // Stops offering and waits until every expected result has come out. A byte
  // may cause no result, so the task lets the block settle before it returns.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Builds and sends one string. Most strings are well formed: filler, start
  // delimiter, field, end delimiter, trailing bytes that must be ignored. The
  // rest is plain noise, a field that is never closed, or a start delimiter
  // that breaks off part way.
  task automatic send_string(output int sent);
    int shape;
    string_bytes.delete();
    shape = $urandom_range(0, 9);
    if (shape <= 6) begin
      repeat ($urandom_range(0, 4)) string_bytes.push_back(near_byte(cur_sp, cur_sl));
      append_pattern(cur_sp, cur_sl, dfe_pkg::LEN_CAP);
      repeat ($urandom_range(0, 6)) string_bytes.push_back(near_byte(cur_ep, cur_el));
      append_pattern(cur_ep, cur_el, dfe_pkg::LEN_CAP);
      repeat ($urandom_range(0, 3)) string_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (shape == 7) begin
      repeat ($urandom_range(1, 12)) string_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (shape == 8) begin
      repeat ($urandom_range(0, 2)) string_bytes.push_back(near_byte(cur_sp, cur_sl));
      append_pattern(cur_sp, cur_sl, dfe_pkg::LEN_CAP);
      repeat ($urandom_range(0, 8)) string_bytes.push_back(near_byte(cur_ep, cur_el));
    end else begin
      append_pattern(cur_sp, cur_sl, $urandom_range(0, 7));
      repeat ($urandom_range(0, 4)) string_bytes.push_back(near_byte(cur_sp, cur_sl));
    end
    if (string_bytes.size() == 0) string_bytes.push_back(8'($urandom_range(0, 255)));
    play_bytes(1'b1);
    sent = string_bytes.size();
  endtask

  initial begin : stimulus
    int sent;
    int total;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset settings a single zero byte is both delimiters. The first
    // string has a zero opener, a field holding the bytes 0x41 and 0xFF, a zero
    // closer and a trailing byte that must be ignored. The second never matches.
    string_bytes = '{8'h00, 8'h41, 8'hFF, 8'h00, 8'h55};
    play_bytes(1'b1);
    string_bytes = '{8'h12, 8'h34};
    play_bytes(1'b1);
    drain();

    // Empty start pattern: the very first byte already belongs to the field.
    program_regs(64'h0, 4'd0, 64'h0A, 4'd1);
    string_bytes = '{8'h61, 8'h62, 8'h0A, 8'h63};
    play_bytes(1'b1);
    drain();

    // Both patterns empty: found on the first byte, whether or not it ends the string.
    program_regs(64'h0, 4'd0, 64'h0, 4'd0);
    string_bytes = '{8'h99};
    play_bytes(1'b1);
    string_bytes = '{8'h5A, 8'h5B};
    play_bytes(1'b1);
    drain();

    // Empty end pattern: found on the byte that completes the start delimiter.
    program_regs(64'h3A, 4'd1, 64'h0, 4'd0);
    string_bytes = '{8'h3A, 8'h11, 8'h12};
    play_bytes(1'b1);
    drain();

    // End length drops to zero in the middle of a field: the bytes still held
    // back are dropped and the found marker follows on the next byte.
    program_regs(64'h3A, 4'd1, 64'h3B3C, 4'd2);
    string_bytes = '{8'h3A, 8'h44, 8'h45};
    play_bytes(1'b0);
    drain();
    program_regs(64'h3A, 4'd1, 64'h3B3C, 4'd0);
    string_bytes = '{8'h46, 8'h47};
    play_bytes(1'b1);
    drain();

    // Random phases, each with its own register setting. The first ones hit the
    // extremes: full-width all-ones and all-zeros delimiters, lengths above the
    // cap, and an empty start or end pattern. The last two run without idling.
    total = 0;
    for (int phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
      calm = (phase_idx >= PHASES - 2);
      case (phase_idx)
        0:       program_regs('1, 4'd8, '0, 4'd8);
        1:       program_regs(pick_word(), 4'd15, pick_word(), 4'd9);
        2:       program_regs(pick_word(), 4'd0, pick_word(), pick_len());
        3:       program_regs(pick_word(), pick_len(), pick_word(), 4'd0);
        default: program_regs(pick_word(), pick_len(), pick_word(), pick_len());
      endcase
      long_hold = (phase_idx == 4);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_string(total);
        sent += total;
      end
      drain();
    end

    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
design/dfe_pkg.sv
design/delimited_field_extractor_core.sv
sim/field_extract_checker.sv
sim/tb.sv
